>>> src/bounded_linked_list_engine_core_defines.svh
`ifndef BOUNDED_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`define BOUNDED_LINKED_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define BLL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define BLL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bll_pkg.sv
`timescale 1ns / 1ps

package bll_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CMD_W   = 4;
  localparam int SLOT_W  = 4;
  localparam int LEN_W   = 5;
  localparam int RV_W    = 36;
  localparam int STAT_W  = 2;
  localparam int VALIN_W = 32;

  localparam logic [RV_W-1:0] RV_SAT  = 36'h7_FFFF_FFFF;
  localparam logic [RV_W-1:0] RV_NONE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD   = 4'd0,
    CMD_INS_TAIL   = 4'd1,
    CMD_INS_AFTER  = 4'd2,
    CMD_INS_BEFORE = 4'd3,
    CMD_DEL_HEAD   = 4'd4,
    CMD_DEL_TAIL   = 4'd5,
    CMD_DEL_VALUE  = 4'd6,
    CMD_CLEAR      = 4'd7,
    CMD_FIND       = 4'd8,
    CMD_MAX        = 4'd9,
    CMD_FIRST_EVEN = 4'd10,
    CMD_LAST_EVEN  = 4'd11,
    CMD_SUM_POS    = 4'd12,
    CMD_COUNT_NEG  = 4'd13,
    CMD_HAS_SQUARE = 4'd14,
    CMD_COUNT_MAX  = 4'd15
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADSLOT = 2'd3
  } status_t;

  typedef struct packed {
    logic ready;
    logic is_square;
  } sq_stat_t;

endpackage

>>> src/bll_ram.sv
`timescale 1ns / 1ps

module bll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bll_isqrt.sv
`timescale 1ns / 1ps

// Digit-by-digit integer square root, one result bit per cycle.
// The value is a perfect square when it is not negative and the remainder ends at zero.
module bll_isqrt #(
  parameter int VALUE_WIDTH = bll_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] operand,
  output bll_pkg::sq_stat_t      stat
);

  localparam int NSTEP = (VALUE_WIDTH + 1) / 2;
  localparam logic [VALUE_WIDTH-1:0] BIT_TOP = VALUE_WIDTH'(1) << (2 * (NSTEP - 1));

  logic [VALUE_WIDTH-1:0] x;
  logic [VALUE_WIDTH-1:0] r;
  logic [VALUE_WIDTH-1:0] bitm;
  logic                   neg;
  logic                   run;
  logic                   ready;
  logic [VALUE_WIDTH:0]   trial;

  assign trial = {1'b0, r} + {1'b0, bitm};

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      ready <= 1'b0;
    end else if (start) begin
      run   <= 1'b1;
      ready <= 1'b0;
    end else if (run) begin
      if ((bitm >> 2) == '0) begin
        run   <= 1'b0;
        ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= operand[VALUE_WIDTH-1];
      x    <= operand[VALUE_WIDTH-1] ? '0 : operand;
      r    <= '0;
      bitm <= BIT_TOP;
    end else if (run) begin
      if ({1'b0, x} >= trial) begin
        x <= VALUE_WIDTH'({1'b0, x} - trial);
        r <= (r >> 1) + bitm;
      end else begin
        r <= r >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  assign stat.ready     = ready;
  assign stat.is_square = !neg && (x == '0);

endmodule

>>> src/bounded_linked_list_engine_core.sv
`timescale 1ns / 1ps
`include "bounded_linked_list_engine_core_defines.svh"

// Channel   Handshake          Payload
// command   start / busy       command, value, node_slot
// result    done (1 cycle)     status, result_value, result_slot, list_length
//
// One command at a time; busy is high from the transfer until done.
// Clear, and commands other than inserts on an empty list, finish in S_CHECK. Walks
// (delete, find, queries) read one linked entry per cycle from the stores.
// Inserts: the free-slot scan from the lowest slot runs alongside the square-root
// unit, and S_FREE waits for both before S_INS and any S_LINK; ins_before adds a walk.
// Synchronous reset empties the list; no clearing pass. done cannot be stalled.
module bounded_linked_list_engine_core #(
  parameter int CAPACITY    = bll_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bll_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [bll_pkg::CMD_W-1:0]   command,
  input  logic [bll_pkg::VALIN_W-1:0] value,
  input  logic [bll_pkg::SLOT_W-1:0]  node_slot,
  output logic                        done,
  output logic [bll_pkg::STAT_W-1:0]  status,
  output logic [bll_pkg::RV_W-1:0]    result_value,
  output logic [bll_pkg::SLOT_W-1:0]  result_slot,
  output logic [bll_pkg::LEN_W-1:0]   list_length
);

  localparam int SW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SWX = (SW > bll_pkg::SLOT_W) ? SW : bll_pkg::SLOT_W;
  localparam int CWX = (CW > bll_pkg::LEN_W) ? CW : bll_pkg::LEN_W;
  localparam int DW  = VALUE_WIDTH + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_QREAD, S_WALK, S_FREE, S_INS, S_LINK
  } state_t;

  state_t          state;
  bll_pkg::cmd_t   cmd_r;
  logic [VALUE_WIDTH-1:0]      val_r;
  logic [bll_pkg::SLOT_W-1:0]  q_r;

  logic [SW-1:0]        head, tail, cur, prev, lq, p, fix_slot;
  logic [CW-1:0]        count, idx;
  logic [CAPACITY-1:0]  used;
  logic                 head_mode;

  logic signed [VALUE_WIDTH-1:0] mx, ev;
  logic [SW-1:0]                 mslot, eslot;
  logic [CW-1:0]                 mhits, negs;
  logic                          have_even, sq_any;
  logic [bll_pkg::RV_W-1:0]      acc;

  // store ports
  logic [SW-1:0]  rd_addr;
  logic [DW-1:0]  d_rdata, d_wdata;
  logic           d_we;
  logic [SW-1:0]  l_rdata, l_wdata, l_waddr;
  logic           l_we;

  logic signed [VALUE_WIDTH-1:0] rval;
  logic                          rsq;
  bll_pkg::sq_stat_t             sq_stat;
  logic                          sq_start;

  logic [SWX-1:0] q_wide;
  logic [SW-1:0]  q_slot;
  logic           qbad, full, first, last, hit, del_unlink;

  logic signed [VALUE_WIDTH-1:0] mx_n, ev_n;
  logic [SW-1:0]                 mslot_n, eslot_n;
  logic [CW-1:0]                 mhits_n, negs_n;
  logic                          heven_n, sq_n, even;
  logic [bll_pkg::RV_W-1:0]      acc_n, acc_sum;

  assign q_wide = SWX'(q_r);
  assign q_slot = q_wide[SW-1:0];
  assign qbad   = !(32'(q_r) < 32'(CAPACITY)) || !used[q_slot];
  assign full   = count == CW'(CAPACITY);
  assign first  = idx == '0;
  assign last   = idx == count - CW'(1);
  assign rval   = d_rdata[VALUE_WIDTH-1:0];
  assign rsq    = d_rdata[VALUE_WIDTH];
  assign hit    = rval == val_r;
  assign even   = !rval[0];

  assign busy        = state != S_IDLE;
  assign list_length = bll_pkg::LEN_W'(CWX'(count));

  assign sq_start = (state == S_CHECK) && !full &&
    ((cmd_r == bll_pkg::CMD_INS_HEAD) || (cmd_r == bll_pkg::CMD_INS_TAIL) ||
     (((cmd_r == bll_pkg::CMD_INS_AFTER) || (cmd_r == bll_pkg::CMD_INS_BEFORE)) && !qbad));

  assign del_unlink = (state == S_WALK) && (cmd_r == bll_pkg::CMD_DEL_VALUE) && hit && !first;

  always_comb begin
    if (state == S_WALK) begin
      rd_addr = l_rdata;
    end else if ((state == S_CHECK) && (cmd_r == bll_pkg::CMD_INS_AFTER)) begin
      rd_addr = q_slot;
    end else begin
      rd_addr = head;
    end
  end

  always_comb begin
    d_we    = state == S_INS;
    d_wdata = {sq_stat.is_square, val_r};
    l_we    = 1'b0;
    l_waddr = p;
    l_wdata = '0;
    if (state == S_INS) begin
      l_we = 1'b1;
      if (head_mode) begin
        l_wdata = (count == '0) ? '0 : head;
      end else if (cmd_r == bll_pkg::CMD_INS_TAIL) begin
        l_wdata = '0;
      end else if (cmd_r == bll_pkg::CMD_INS_AFTER) begin
        l_wdata = lq;
      end else begin
        l_wdata = q_slot;
      end
    end else if (state == S_LINK) begin
      l_we    = 1'b1;
      l_waddr = fix_slot;
      l_wdata = p;
    end else if (del_unlink) begin
      l_we    = 1'b1;
      l_waddr = prev;
      l_wdata = l_rdata;
    end
  end

  // running query values with the current node folded in
  always_comb begin
    if (first || (rval > mx)) begin
      mx_n    = rval;
      mslot_n = cur;
      mhits_n = CW'(1);
    end else begin
      mx_n    = mx;
      mslot_n = mslot;
      mhits_n = mhits + CW'(rval == mx);
    end
    heven_n = (!first && have_even) || even;
    ev_n    = ev;
    eslot_n = eslot;
    if (even && (first || !have_even || (cmd_r == bll_pkg::CMD_LAST_EVEN))) begin
      ev_n    = rval;
      eslot_n = cur;
    end
    acc_sum = (first ? '0 : acc) +
              ((rval > 0) ? bll_pkg::RV_W'(unsigned'(rval)) : '0);
    acc_n   = (acc_sum > bll_pkg::RV_SAT) ? bll_pkg::RV_SAT : acc_sum;
    negs_n  = (first ? '0 : negs) + CW'(rval < 0);
    sq_n    = (!first && sq_any) || rsq;
  end

  bll_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (p),
    .wdata (d_wdata),
    .raddr (rd_addr),
    .rdata (d_rdata)
  );

  bll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (rd_addr),
    .rdata (l_rdata)
  );

  bll_isqrt #(.VALUE_WIDTH(VALUE_WIDTH)) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (val_r),
    .stat    (sq_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      used      <= '0;
      head_mode <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r <= bll_pkg::cmd_t'(command);
            val_r <= value[VALUE_WIDTH-1:0];
            q_r   <= node_slot;
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          cur          <= head;
          idx          <= '0;
          p            <= '0;
          head_mode    <= cmd_r == bll_pkg::CMD_INS_HEAD;
          result_value <= '0;
          result_slot  <= '0;
          status       <= bll_pkg::ST_OK;
          unique case (cmd_r)
            bll_pkg::CMD_INS_HEAD, bll_pkg::CMD_INS_TAIL: begin
              if (full) begin
                status <= bll_pkg::ST_FULL;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                state <= S_FREE;
              end
            end
            bll_pkg::CMD_INS_AFTER, bll_pkg::CMD_INS_BEFORE: begin
              if (qbad) begin
                status <= bll_pkg::ST_BADSLOT;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else if (full) begin
                status <= bll_pkg::ST_FULL;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else if (cmd_r == bll_pkg::CMD_INS_AFTER) begin
                state <= S_QREAD;
              end else if (q_slot == head) begin
                head_mode <= 1'b1;
                state     <= S_FREE;
              end else begin
                state <= S_WALK;
              end
            end
            bll_pkg::CMD_CLEAR: begin
              used  <= '0;
              head  <= '0;
              tail  <= '0;
              count <= '0;
              done  <= 1'b1;
              state <= S_IDLE;
            end
            bll_pkg::CMD_DEL_HEAD, bll_pkg::CMD_DEL_TAIL, bll_pkg::CMD_DEL_VALUE,
            bll_pkg::CMD_FIND: begin
              if (count == '0) begin
                status <= bll_pkg::ST_NONE;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else if ((cmd_r == bll_pkg::CMD_DEL_TAIL) && (count == CW'(1))) begin
                used[head]  <= 1'b0;
                result_slot <= bll_pkg::SLOT_W'(SWX'(tail));
                head        <= '0;
                tail        <= '0;
                count       <= '0;
                done        <= 1'b1;
                state       <= S_IDLE;
              end else begin
                state <= S_WALK;
              end
            end
            bll_pkg::CMD_MAX, bll_pkg::CMD_FIRST_EVEN, bll_pkg::CMD_LAST_EVEN,
            bll_pkg::CMD_SUM_POS, bll_pkg::CMD_COUNT_NEG, bll_pkg::CMD_HAS_SQUARE,
            bll_pkg::CMD_COUNT_MAX: begin
              if (count == '0) begin
                if ((cmd_r == bll_pkg::CMD_MAX) || (cmd_r == bll_pkg::CMD_FIRST_EVEN) ||
                    (cmd_r == bll_pkg::CMD_LAST_EVEN)) begin
                  status       <= bll_pkg::ST_NONE;
                  result_value <= bll_pkg::RV_NONE;
                end else if (cmd_r == bll_pkg::CMD_COUNT_MAX) begin
                  status <= bll_pkg::ST_NONE;
                end
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                state <= S_WALK;
              end
            end
          endcase
        end

        S_QREAD: begin
          lq    <= l_rdata;
          state <= S_FREE;
        end

        S_WALK: begin
          // advance by default; the finishing arms override state
          cur <= l_rdata;
          idx <= idx + CW'(1);
          unique case (cmd_r)
            bll_pkg::CMD_INS_BEFORE: begin
              if (l_rdata == q_slot) begin
                prev  <= cur;
                state <= S_FREE;
              end else if (idx == count - CW'(2)) begin
                status <= bll_pkg::ST_BADSLOT;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end
            bll_pkg::CMD_DEL_HEAD: begin
              used[cur]   <= 1'b0;
              count       <= count - CW'(1);
              head        <= (count == CW'(1)) ? '0 : l_rdata;
              tail        <= (count == CW'(1)) ? '0 : tail;
              result_slot <= bll_pkg::SLOT_W'(SWX'(cur));
              done        <= 1'b1;
              state       <= S_IDLE;
            end
            bll_pkg::CMD_DEL_TAIL: begin
              if (idx == count - CW'(2)) begin
                used[tail]  <= 1'b0;
                tail        <= cur;
                count       <= count - CW'(1);
                result_slot <= bll_pkg::SLOT_W'(SWX'(tail));
                done        <= 1'b1;
                state       <= S_IDLE;
              end
            end
            bll_pkg::CMD_DEL_VALUE, bll_pkg::CMD_FIND: begin
              if (hit) begin
                result_slot <= bll_pkg::SLOT_W'(SWX'(cur));
                done        <= 1'b1;
                state       <= S_IDLE;
                if (cmd_r == bll_pkg::CMD_DEL_VALUE) begin
                  used[cur] <= 1'b0;
                  count     <= count - CW'(1);
                  if (first) begin
                    head <= (count == CW'(1)) ? '0 : l_rdata;
                    tail <= (count == CW'(1)) ? '0 : tail;
                  end else if (cur == tail) begin
                    tail <= prev;
                  end
                end
              end else if (last) begin
                status <= bll_pkg::ST_NONE;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                prev <= cur;
              end
            end
            bll_pkg::CMD_INS_HEAD, bll_pkg::CMD_INS_TAIL, bll_pkg::CMD_INS_AFTER,
            bll_pkg::CMD_CLEAR: begin
              state <= S_IDLE;
            end
            bll_pkg::CMD_MAX, bll_pkg::CMD_FIRST_EVEN, bll_pkg::CMD_LAST_EVEN,
            bll_pkg::CMD_SUM_POS, bll_pkg::CMD_COUNT_NEG, bll_pkg::CMD_HAS_SQUARE,
            bll_pkg::CMD_COUNT_MAX: begin
              mx        <= mx_n;
              mslot     <= mslot_n;
              mhits     <= mhits_n;
              ev        <= ev_n;
              eslot     <= eslot_n;
              have_even <= heven_n;
              acc       <= acc_n;
              negs      <= negs_n;
              sq_any    <= sq_n;
              if (last) begin
                done  <= 1'b1;
                state <= S_IDLE;
                unique case (cmd_r)
                  bll_pkg::CMD_MAX: begin
                    result_value <= bll_pkg::RV_W'(mx_n);
                    result_slot  <= bll_pkg::SLOT_W'(SWX'(mslot_n));
                  end
                  bll_pkg::CMD_FIRST_EVEN, bll_pkg::CMD_LAST_EVEN: begin
                    if (heven_n) begin
                      result_value <= bll_pkg::RV_W'(ev_n);
                      result_slot  <= bll_pkg::SLOT_W'(SWX'(eslot_n));
                    end else begin
                      status       <= bll_pkg::ST_NONE;
                      result_value <= bll_pkg::RV_NONE;
                    end
                  end
                  bll_pkg::CMD_SUM_POS:    result_value <= acc_n;
                  bll_pkg::CMD_COUNT_NEG:  result_value <= bll_pkg::RV_W'(negs_n);
                  bll_pkg::CMD_HAS_SQUARE: result_value <= bll_pkg::RV_W'(sq_n);
                  default:                 result_value <= bll_pkg::RV_W'(mhits_n);
                endcase
              end
            end
          endcase
        end

        S_FREE: begin
          // hold p on the lowest free slot until the square flag is ready
          if (used[p]) begin
            p <= p + SW'(1);
          end else if (sq_stat.ready) begin
            state <= S_INS;
          end
        end

        S_INS: begin
          used[p]     <= 1'b1;
          count       <= count + CW'(1);
          result_slot <= bll_pkg::SLOT_W'(SWX'(p));
          if (head_mode) begin
            head <= p;
            if (count == '0) begin
              tail <= p;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (cmd_r == bll_pkg::CMD_INS_TAIL) begin
            tail     <= p;
            fix_slot <= tail;
            if (count == '0) begin
              head  <= p;
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_LINK;
            end
          end else if (cmd_r == bll_pkg::CMD_INS_AFTER) begin
            fix_slot <= q_slot;
            if (q_slot == tail) begin
              tail <= p;
            end
            state <= S_LINK;
          end else begin
            fix_slot <= prev;
            state    <= S_LINK;
          end
        end

        S_LINK: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `BLL_ASSERT_NOW(a_count_cap, clk, rst, 1'b1, count <= CW'(CAPACITY), "count exceeds capacity")
  `BLL_ASSERT_NOW(a_empty_ptrs, clk, rst, count == '0, (head | tail) == '0, "stale pointers")
  `BLL_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "accepted command not busy")
  `BLL_ASSERT_NOW(a_done_after, clk, rst, done, !busy && $past(busy), "result without command")

endmodule

>>> tb/tb_bounded_linked_list_engine_core.sv
`timescale 1ns / 1ps

module tb_bounded_linked_list_engine_core;

  localparam int NSLOT = 16;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    bll_pkg::status_t         st;
    logic [bll_pkg::RV_W-1:0] rv;
    logic [3:0]               rs;
    logic [4:0]               len;
  } outcome_t;

  typedef struct {
    bll_pkg::cmd_t c;
    logic [31:0]   v;
    logic [3:0]    q;
    bit            typed;
    outcome_t      e;
  } row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [bll_pkg::CMD_W-1:0] command;
  logic [bll_pkg::VALIN_W-1:0] value;
  logic [bll_pkg::SLOT_W-1:0] node_slot;
  logic done;
  logic [bll_pkg::STAT_W-1:0] status;
  logic [bll_pkg::RV_W-1:0] result_value;
  logic [bll_pkg::SLOT_W-1:0] result_slot;
  logic [bll_pkg::LEN_W-1:0] list_length;

  // Shadow list
  logic signed [31:0] node_val [NSLOT];
  logic [3:0] node_next [NSLOT];
  bit node_sq [NSLOT];
  bit node_used [NSLOT];
  logic [3:0] head_p, tail_p;
  int node_cnt;

  outcome_t pending_results[$];
  bit typed_now;
  outcome_t typed_exp;
  bit failed;
  int idle_cycles;
  int idle_pct;

  bounded_linked_list_engine_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .value(value), .node_slot(node_slot),
    .done(done), .status(status), .result_value(result_value),
    .result_slot(result_slot), .list_length(list_length)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_perfect_square(logic signed [31:0] n);
    longint r, t;
    r = 0;
    if (n < 0) return 1'b0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= longint'(n)) r = t;
    end
    return r * r == longint'(n);
  endfunction

  function automatic int grab_slot(logic signed [31:0] v);
    int p;
    p = 0;
    while (node_used[p]) p++;
    node_val[p] = v;
    node_sq[p] = is_perfect_square(v);
    node_used[p] = 1'b1;
    node_next[p] = '0;
    return p;
  endfunction

  task automatic model_list(input bll_pkg::cmd_t c, input logic signed [31:0] v,
                            input logic [3:0] q, output outcome_t e);
    int chain [NSLOT];
    int p, k, hits, pick;
    longint best, sum;
    logic [3:0] cur;
    bit flag;
    cur = head_p;
    for (int i = 0; i < node_cnt; i++) begin
      chain[i] = int'(cur);
      cur = node_next[cur];
    end
    e = '{bll_pkg::ST_OK, '0, '0, '0};
    case (c)
      bll_pkg::CMD_INS_HEAD, bll_pkg::CMD_INS_TAIL, bll_pkg::CMD_INS_AFTER,
      bll_pkg::CMD_INS_BEFORE: begin
        if ((c == bll_pkg::CMD_INS_AFTER || c == bll_pkg::CMD_INS_BEFORE) &&
            !node_used[q]) begin
          e.st = bll_pkg::ST_BADSLOT;
        end else if (node_cnt == NSLOT) begin
          e.st = bll_pkg::ST_FULL;
        end else if (c == bll_pkg::CMD_INS_HEAD ||
                     (c == bll_pkg::CMD_INS_BEFORE && q == head_p)) begin
          p = grab_slot(v);
          if (node_cnt == 0) tail_p = 4'(p);
          else node_next[p] = head_p;
          head_p = 4'(p);
          node_cnt++;
          e.rs = 4'(p);
        end else if (c == bll_pkg::CMD_INS_TAIL) begin
          p = grab_slot(v);
          if (node_cnt == 0) head_p = 4'(p);
          else node_next[tail_p] = 4'(p);
          tail_p = 4'(p);
          node_cnt++;
          e.rs = 4'(p);
        end else if (c == bll_pkg::CMD_INS_AFTER) begin
          p = grab_slot(v);
          node_next[p] = node_next[q];
          node_next[q] = 4'(p);
          if (q == tail_p) tail_p = 4'(p);
          node_cnt++;
          e.rs = 4'(p);
        end else begin
          k = -1;
          for (int i = 0; i + 1 < node_cnt; i++)
            if (k < 0 && chain[i+1] == int'(q)) k = i;
          if (k < 0) begin
            e.st = bll_pkg::ST_BADSLOT;
          end else begin
            p = grab_slot(v);
            node_next[p] = q;
            node_next[chain[k]] = 4'(p);
            node_cnt++;
            e.rs = 4'(p);
          end
        end
      end
      bll_pkg::CMD_DEL_HEAD, bll_pkg::CMD_DEL_TAIL: begin
        if (node_cnt == 0) begin
          e.st = bll_pkg::ST_NONE;
        end else begin
          k = (c == bll_pkg::CMD_DEL_HEAD) ? 0 : node_cnt - 1;
          e.rs = 4'(chain[k]);
          node_used[chain[k]] = 1'b0;
          node_cnt--;
          if (k == 0) head_p = node_next[chain[0]];
          else tail_p = 4'(chain[k-1]);
          if (node_cnt == 0) begin
            head_p = '0;
            tail_p = '0;
          end
        end
      end
      bll_pkg::CMD_DEL_VALUE, bll_pkg::CMD_FIND: begin
        k = -1;
        for (int i = 0; i < node_cnt; i++)
          if (k < 0 && node_val[chain[i]] == v) k = i;
        if (k < 0) begin
          e.st = bll_pkg::ST_NONE;
        end else begin
          e.rs = 4'(chain[k]);
          if (c == bll_pkg::CMD_DEL_VALUE) begin
            node_used[chain[k]] = 1'b0;
            if (k == 0) begin
              head_p = node_next[chain[0]];
            end else begin
              node_next[chain[k-1]] = node_next[chain[k]];
              if (chain[k] == int'(tail_p)) tail_p = 4'(chain[k-1]);
            end
            node_cnt--;
            if (node_cnt == 0) begin
              head_p = '0;
              tail_p = '0;
            end
          end
        end
      end
      bll_pkg::CMD_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) node_used[i] = 1'b0;
        head_p = '0;
        tail_p = '0;
        node_cnt = 0;
      end
      default: begin
        best = 0;
        sum = 0;
        hits = 0;
        flag = 1'b0;
        pick = -1;
        for (int i = 0; i < node_cnt; i++) begin
          if (i == 0 || node_val[chain[i]] > best) begin
            best = node_val[chain[i]];
            e.rs = 4'(chain[i]);
          end
          if (node_val[chain[i]] > 0) sum += node_val[chain[i]];
          if (node_val[chain[i]] < 0) hits++;
          if (node_sq[chain[i]]) flag = 1'b1;
          if (!node_val[chain[i]][0] && (c == bll_pkg::CMD_LAST_EVEN || pick < 0))
            pick = chain[i];
        end
        case (c)
          bll_pkg::CMD_MAX: begin
            if (node_cnt == 0) begin
              e.st = bll_pkg::ST_NONE;
              e.rv = bll_pkg::RV_NONE;
            end else begin
              e.rv = bll_pkg::RV_W'(best);
            end
          end
          bll_pkg::CMD_FIRST_EVEN, bll_pkg::CMD_LAST_EVEN: begin
            if (pick < 0) begin
              e.st = bll_pkg::ST_NONE;
              e.rv = bll_pkg::RV_NONE;
              e.rs = '0;
            end else begin
              e.rv = bll_pkg::RV_W'(longint'(node_val[pick]));
              e.rs = 4'(pick);
            end
          end
          bll_pkg::CMD_SUM_POS:
            e.rv = (sum > longint'(bll_pkg::RV_SAT)) ? bll_pkg::RV_SAT : bll_pkg::RV_W'(sum);
          bll_pkg::CMD_COUNT_NEG: e.rv = bll_pkg::RV_W'(hits);
          bll_pkg::CMD_HAS_SQUARE: e.rv = bll_pkg::RV_W'(flag);
          default: begin
            hits = 0;
            for (int i = 0; i < node_cnt; i++)
              if (node_val[chain[i]] == best) hits++;
            if (node_cnt == 0) e.st = bll_pkg::ST_NONE;
            else e.rv = bll_pkg::RV_W'(hits);
          end
        endcase
        if (c != bll_pkg::CMD_MAX && c != bll_pkg::CMD_FIRST_EVEN &&
            c != bll_pkg::CMD_LAST_EVEN) e.rs = '0;
      end
    endcase
    e.len = 5'(node_cnt);
  endtask

  always @(posedge clk) begin
    outcome_t e, got;
    if (!rst) begin
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start && !busy) begin
        model_list(bll_pkg::cmd_t'(command), value, node_slot, e);
        pending_results.push_back(typed_now ? typed_exp : e);
      end
      if (done) begin
        got = '{bll_pkg::status_t'(status), result_value, result_slot, list_length};
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: actual %p", $time, got);
          failed = 1'b1;
        end else begin
          e = pending_results.pop_front();
          if (got !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, got);
            failed = 1'b1;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_bounded_linked_list_engine_core failed");
        $finish;
      end
    end
  end

  task automatic send(input bll_pkg::cmd_t c, input logic [31:0] v, input logic [3:0] q,
                      input bit typed, input outcome_t e);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= c;
    value <= v;
    node_slot <= q;
    typed_now <= typed;
    typed_exp <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    int kind;
    int s;
    kind = $urandom_range(9);
    if (kind < 4) return 32'($signed($urandom_range(80)) - 40);
    if (kind == 4) begin
      s = $urandom_range(46340);
      return 32'(s * s);
    end
    if (kind == 5) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic int rand_used_slot();
    int list [$];
    for (int i = 0; i < NSLOT; i++)
      if (node_used[i]) list.push_back(i);
    if (list.size() == 0) return -1;
    return list[$urandom_range(list.size() - 1)];
  endfunction

  row_t dir_rows [23] = '{
    '{bll_pkg::CMD_DEL_HEAD,   32'h0,         4'd0,  1'b1,
      '{bll_pkg::ST_NONE, '0, 4'd0, 5'd0}},
    '{bll_pkg::CMD_MAX,        32'h0,         4'd0,  1'b1,
      '{bll_pkg::ST_NONE, '1, 4'd0, 5'd0}},
    '{bll_pkg::CMD_COUNT_MAX,  32'h0,         4'd0,  1'b1,
      '{bll_pkg::ST_NONE, '0, 4'd0, 5'd0}},
    '{bll_pkg::CMD_SUM_POS,    32'h0,         4'd0,  1'b1,
      '{bll_pkg::ST_OK, '0, 4'd0, 5'd0}},
    '{bll_pkg::CMD_INS_HEAD,   32'h7FFF_FFFF, 4'd0,  1'b1,
      '{bll_pkg::ST_OK, '0, 4'd0, 5'd1}},
    '{bll_pkg::CMD_INS_TAIL,   32'h8000_0000, 4'd15, 1'b1,
      '{bll_pkg::ST_OK, '0, 4'd1, 5'd2}},
    '{bll_pkg::CMD_INS_AFTER,  32'h5,         4'd15, 1'b1,
      '{bll_pkg::ST_BADSLOT, '0, 4'd0, 5'd2}},
    '{bll_pkg::CMD_INS_BEFORE, 32'd16,        4'd1,  1'b0, '0},
    '{bll_pkg::CMD_INS_AFTER,  32'hFFFF_FFFC, 4'd0,  1'b0, '0},
    '{bll_pkg::CMD_INS_HEAD,   32'h0,         4'd0,  1'b0, '0},
    '{bll_pkg::CMD_HAS_SQUARE, 32'h0,         4'd0,  1'b0, '0},
    '{bll_pkg::CMD_FIRST_EVEN, 32'h0,         4'd0,  1'b0, '0},
    '{bll_pkg::CMD_LAST_EVEN,  32'h0,         4'd0,  1'b0, '0},
    '{bll_pkg::CMD_COUNT_NEG,  32'h0,         4'd0,  1'b0, '0},
    '{bll_pkg::CMD_SUM_POS,    32'h0,         4'd0,  1'b0, '0},
    '{bll_pkg::CMD_COUNT_MAX,  32'h0,         4'd0,  1'b0, '0},
    '{bll_pkg::CMD_MAX,        32'h0,         4'd0,  1'b0, '0},
    '{bll_pkg::CMD_FIND,       32'd16,        4'd0,  1'b0, '0},
    '{bll_pkg::CMD_DEL_VALUE,  32'd16,        4'd0,  1'b0, '0},
    '{bll_pkg::CMD_DEL_VALUE,  32'd99,        4'd0,  1'b1,
      '{bll_pkg::ST_NONE, '0, 4'd0, 5'd4}},
    '{bll_pkg::CMD_DEL_TAIL,   32'h0,         4'd0,  1'b0, '0},
    '{bll_pkg::CMD_DEL_HEAD,   32'h0,         4'd0,  1'b0, '0},
    '{bll_pkg::CMD_CLEAR,      32'h0,         4'd0,  1'b1,
      '{bll_pkg::ST_OK, '0, 4'd0, 5'd0}}
  };

  initial begin
    bll_pkg::cmd_t c;
    logic [31:0] v;
    int q, r, ins_pct;
    rst = 1'b1;
    start = 1'b0;
    command = '0;
    value = '0;
    node_slot = '0;
    typed_now = 1'b0;
    typed_exp = '0;
    failed = 1'b0;
    idle_cycles = 0;
    idle_pct = 0;
    ins_pct = 55;
    head_p = '0;
    tail_p = '0;
    node_cnt = 0;
    for (int i = 0; i < NSLOT; i++) node_used[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send(dir_rows[i].c, dir_rows[i].v, dir_rows[i].q, dir_rows[i].typed, dir_rows[i].e);

    for (int n = 0; n < 1550; n++) begin
      case (n / 400)
        0: idle_pct = 0;
        1: idle_pct = 45;
        2: idle_pct = 9;
        default: idle_pct = 0;
      endcase
      // swing the list between full and empty
      if (n % 60 == 0) ins_pct = ((n / 60) % 2 != 0) ? 25 : 55;
      r = $urandom_range(99);
      if (r == 99) c = bll_pkg::CMD_CLEAR;
      else if (r < ins_pct) c = bll_pkg::cmd_t'($urandom_range(3));
      else if (r < ins_pct + 25) c = bll_pkg::cmd_t'($urandom_range(6, 4));
      else c = bll_pkg::cmd_t'($urandom_range(15, 8));
      v = rand_value();
      q = rand_used_slot();
      if ((c == bll_pkg::CMD_DEL_VALUE || c == bll_pkg::CMD_FIND) && q >= 0 &&
          $urandom_range(9) < 6)
        v = node_val[q];
      if (q < 0 || $urandom_range(9) < 2) q = $urandom_range(15);
      send(c, v, q[3:0], 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (!failed) begin
      $display("tb_bounded_linked_list_engine_core passed");
    end else begin
      $display("tb_bounded_linked_list_engine_core failed");
    end
    $finish;
  end

endmodule
